// File: design/mpsm_pkg.sv
package mpsm_pkg;

    // Default sizes of the automaton
    localparam int NODES_DEF        = 256;
    localparam int ALPHABET_DEF     = 26;
    localparam int MAX_DEPTH_DEF    = 16;
    localparam int MAX_PATTERNS_DEF = 64;

    // Matches reported per text letter at most
    localparam int MAX_RESULTS = 16;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_LONG     = 3'd2;
    localparam logic [2:0] ST_SEARCHED = 3'd3;
    localparam logic [2:0] ST_MANY     = 3'd4;

    // Result beat sources
    localparam logic [1:0] EM_INS  = 2'd0;
    localparam logic [1:0] EM_PEND = 2'd1;
    localparam logic [1:0] EM_SRCH = 2'd2;
    localparam logic [1:0] EM_ZERO = 2'd3;

    typedef struct packed {
        logic       take;
        logic       ins_begin;
        logic       set_long;
        logic       ld_addr;
        logic       lk_search;
        logic       ins_descend;
        logic       set_full;
        logic       alloc;
        logic       ins_finish;
        logic       sr_begin;
        logic       try_init;
        logic       sr_step;
        logic       sr_next;
        logic       sr_hit;
        logic       sr_shift;
        logic       clear_all;
        logic       emit;
        logic [1:0] emit_sel;
    } mpsm_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       drop_nz;
        logic       depth_full;
        logic       hit;
        logic       node_full;
        logic       off_eq_len;
        logic       j_eq_len;
        logic       term;
        logic       pend_v;
        logic       res_last;
        logic       shift_done;
        logic       out_free;
    } mpsm_stat_t;

endpackage

// File: design/mpsm_ctrl.sv
module mpsm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mpsm_pkg::mpsm_stat_t   stat,
    output mpsm_pkg::mpsm_cmd_t    cmd
);
    import mpsm_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_INS_A   = 5'd2;
    localparam logic [4:0] S_INS_B   = 5'd3;
    localparam logic [4:0] S_INS_C   = 5'd4;
    localparam logic [4:0] S_INS_D   = 5'd5;
    localparam logic [4:0] S_INS_E   = 5'd6;
    localparam logic [4:0] S_INS_FIN = 5'd7;
    localparam logic [4:0] S_SR_A    = 5'd8;
    localparam logic [4:0] S_SR_TRY  = 5'd9;
    localparam logic [4:0] S_SR_LOOK = 5'd10;
    localparam logic [4:0] S_SR_C    = 5'd11;
    localparam logic [4:0] S_SR_D    = 5'd12;
    localparam logic [4:0] S_SR_E    = 5'd13;
    localparam logic [4:0] S_SR_HIT  = 5'd14;
    localparam logic [4:0] S_SR_SHFT = 5'd15;
    localparam logic [4:0] S_SR_OUT  = 5'd16;
    localparam logic [4:0] S_ZERO    = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Sequence the datapath
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.func == FUNC_INSERT)
                    state_next = S_INS_A;
                else if (stat.func == FUNC_SEARCH)
                    state_next = S_SR_A;
                else
                    state_next = S_ZERO;
            end
            S_INS_A:
            begin
                cmd.ins_begin = 1'b1;
                state_next    = S_INS_B;
            end
            S_INS_B:
            begin
                if (stat.drop_nz)
                    state_next = S_INS_FIN;
                else if (stat.depth_full)
                begin
                    cmd.set_long = 1'b1;
                    state_next   = S_INS_FIN;
                end
                else
                begin
                    cmd.ld_addr = 1'b1;
                    state_next  = S_INS_C;
                end
            end
            S_INS_C: state_next = S_INS_D;
            S_INS_D: state_next = S_INS_E;
            S_INS_E:
            begin
                if (stat.hit)
                    cmd.ins_descend = 1'b1;
                else if (stat.node_full)
                    cmd.set_full = 1'b1;
                else
                    cmd.alloc = 1'b1;
                state_next = S_INS_FIN;
            end
            S_INS_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.ins_finish = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EM_INS;
                    state_next     = S_IDLE;
                end
            end
            S_SR_A:
            begin
                cmd.sr_begin = 1'b1;
                state_next   = S_SR_TRY;
            end
            S_SR_TRY:
            begin
                if (stat.off_eq_len)
                    state_next = S_SR_SHFT;
                else
                begin
                    cmd.try_init = 1'b1;
                    state_next   = S_SR_LOOK;
                end
            end
            S_SR_LOOK:
            begin
                if (stat.j_eq_len)
                    state_next = S_SR_HIT;
                else
                begin
                    cmd.ld_addr   = 1'b1;
                    cmd.lk_search = 1'b1;
                    state_next    = S_SR_C;
                end
            end
            S_SR_C: state_next = S_SR_D;
            S_SR_D: state_next = S_SR_E;
            S_SR_E:
            begin
                if (stat.hit)
                begin
                    cmd.sr_step = 1'b1;
                    state_next  = S_SR_LOOK;
                end
                else
                begin
                    cmd.sr_next = 1'b1;
                    state_next  = S_SR_TRY;
                end
            end
            S_SR_HIT:
            begin
                // Hold while a pending match cannot leave
                if (!(stat.term && stat.pend_v) || stat.out_free)
                begin
                    cmd.sr_hit = 1'b1;
                    if (stat.term && stat.pend_v)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EM_PEND;
                    end
                    if (stat.term && stat.res_last)
                        state_next = S_SR_SHFT;
                    else
                        state_next = S_SR_TRY;
                end
            end
            S_SR_SHFT:
            begin
                cmd.sr_shift = 1'b1;
                if (stat.shift_done)
                    state_next = S_SR_OUT;
            end
            S_SR_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EM_SRCH;
                    state_next   = S_IDLE;
                end
            end
            S_ZERO:
            begin
                if (stat.out_free)
                begin
                    cmd.clear_all = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EM_ZERO;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: design/mpsm_dp.sv
module mpsm_dp #(
    parameter int NODES        = mpsm_pkg::NODES_DEF,
    parameter int ALPHABET     = mpsm_pkg::ALPHABET_DEF,
    parameter int MAX_DEPTH    = mpsm_pkg::MAX_DEPTH_DEF,
    parameter int MAX_PATTERNS = mpsm_pkg::MAX_PATTERNS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   s_tlast,
    input  mpsm_pkg::mpsm_cmd_t    cmd,
    output mpsm_pkg::mpsm_stat_t   stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import mpsm_pkg::*;

    localparam int NW    = $clog2(NODES);
    localparam int NCW   = $clog2(NODES + 1);
    localparam int LW    = $clog2(ALPHABET);
    localparam int SLOTS = NODES * ALPHABET;
    localparam int AW    = $clog2(SLOTS);
    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int PW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PCW   = $clog2(MAX_PATTERNS + 1);
    localparam int BD    = MAX_DEPTH + 1;
    localparam int IW    = $clog2(BD);
    localparam int BLW   = $clog2(BD + 1);
    localparam int RW    = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [NW-1:0] node;
        logic [LW-1:0] letter;
    } key_t;

    typedef struct packed {
        logic          term;
        logic [PW-1:0] pat;
    } mark_t;

    // Tables: child slots, node parent links, node terminal marks
    logic [NW-1:0] child_mem [SLOTS];
    key_t          link_mem  [NODES];
    mark_t         mark_mem  [NODES];

    logic [NW-1:0] child_q;
    key_t          link_q;
    mark_t         mark_q;

    // Latched input beat
    logic [1:0] func_reg;
    logic [4:0] letter_reg;
    logic       first_reg;
    logic       fin_reg;

    // Automaton control state
    logic [NCW-1:0] nc_reg;
    logic [PCW-1:0] pc_reg;
    logic           in_pat_reg;
    logic [2:0]     drop_reg;
    logic           searched_reg;
    logic [NW-1:0]  cur_reg;
    logic [DW-1:0]  depth_reg;

    // Search walk state
    logic [LW-1:0]  tbuf_reg [BD];
    logic [BLW-1:0] len_reg;
    logic [BLW-1:0] off_reg;
    logic [BLW-1:0] j_reg;
    logic [NW-1:0]  walk_reg;
    logic           found_reg;
    logic [BLW-1:0] new_off_reg;
    logic [RW-1:0]  nres_reg;
    logic           pend_v_reg;
    logic [PW-1:0]  pend_pat_reg;

    // Lookup address and key
    logic [AW-1:0] addr_reg;
    key_t          key_reg;

    // Result register
    logic       out_valid_reg;
    logic       out_mv_reg;
    logic [5:0] out_num_reg;
    logic [2:0] out_st_reg;
    logic       out_last_reg;

    logic [LW-1:0] mod_tab [32];
    logic [LW-1:0] c;
    logic          begin_start;
    logic [2:0]    drop_base;
    logic [2:0]    drop_next;
    logic [NW-1:0] lk_node;
    logic [LW-1:0] lk_letter;
    logic [IW-1:0] app_idx;
    logic          hit;
    logic          out_free;
    logic          do_clear;

    // Reduce the letter modulo the alphabet size
    for (genvar g = 0; g < 32; g++)
    begin : g_mod
        assign mod_tab[g] = LW'(g % ALPHABET);
    end
    assign c = mod_tab[letter_reg];

    // Pattern start and drop decision
    assign begin_start = first_reg || !in_pat_reg;
    assign drop_base   = begin_start ?
                         ((pc_reg >= PCW'(MAX_PATTERNS)) ? ST_MANY : ST_OK) : drop_reg;
    assign drop_next   = (drop_base == ST_OK && searched_reg) ? ST_SEARCHED : drop_base;

    // Lookup source
    assign lk_node   = cmd.lk_search ? walk_reg : cur_reg;
    assign lk_letter = cmd.lk_search ? tbuf_reg[j_reg[IW-1:0]] : c;
    assign app_idx   = first_reg ? '0 : len_reg[IW-1:0];

    // A child slot counts only if the node it names was built under this slot
    assign hit = (child_q != '0) && (NCW'(child_q) < nc_reg) && (link_q == key_reg);

    assign out_free = !out_valid_reg || m_tready;
    assign do_clear = cmd.clear_all && (func_reg == FUNC_CLEAR);

    assign stat.func       = func_reg;
    assign stat.drop_nz    = (drop_reg != ST_OK);
    assign stat.depth_full = (depth_reg == DW'(MAX_DEPTH));
    assign stat.hit        = hit;
    assign stat.node_full  = (nc_reg == NCW'(NODES));
    assign stat.off_eq_len = (off_reg == len_reg);
    assign stat.j_eq_len   = (j_reg == len_reg);
    assign stat.term       = mark_q.term;
    assign stat.pend_v     = pend_v_reg;
    assign stat.res_last   = (nres_reg == RW'(MAX_RESULTS - 1));
    assign stat.shift_done = !found_reg || (new_off_reg == '0);
    assign stat.out_free   = out_free;

    // Table reads and writes
    always_ff @(posedge clk)
    begin
        child_q <= child_mem[addr_reg];
        link_q  <= link_mem[child_q];
        mark_q  <= mark_mem[child_q];
        if (cmd.alloc)
        begin
            child_mem[addr_reg]       <= nc_reg[NW-1:0];
            link_mem[nc_reg[NW-1:0]]  <= key_reg;
            mark_mem[nc_reg[NW-1:0]]  <= '0;
        end
        if (cmd.ins_finish && fin_reg && drop_reg == ST_OK)
            mark_mem[cur_reg] <= '{term: 1'b1, pat: PW'(pc_reg)};
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg   <= s_tuser;
            letter_reg <= s_tdata[4:0];
            first_reg  <= s_tdata[5];
            fin_reg    <= s_tlast;
        end
        if (cmd.ld_addr)
        begin
            addr_reg <= AW'(lk_node) * AW'(ALPHABET) + AW'(lk_letter);
            key_reg  <= '{node: lk_node, letter: lk_letter};
        end
        // Append the text letter, or drop leading letters after the walk
        if (cmd.sr_begin)
            tbuf_reg[app_idx] <= c;
        else if (cmd.sr_shift && found_reg && new_off_reg != '0)
        begin
            for (int k = 0; k < BD - 1; k++)
                tbuf_reg[k] <= tbuf_reg[k + 1];
        end
        if (cmd.sr_hit && mark_q.term)
            pend_pat_reg <= mark_q.pat;
        if (cmd.emit)
        begin
            unique case (cmd.emit_sel)
                EM_INS:
                begin
                    out_mv_reg   <= 1'b0;
                    out_num_reg  <= (fin_reg && drop_reg == ST_OK) ? 6'(pc_reg) : 6'd0;
                    out_st_reg   <= drop_reg;
                    out_last_reg <= 1'b1;
                end
                EM_PEND:
                begin
                    out_mv_reg   <= 1'b1;
                    out_num_reg  <= 6'(pend_pat_reg);
                    out_st_reg   <= ST_OK;
                    out_last_reg <= 1'b0;
                end
                EM_SRCH:
                begin
                    out_mv_reg   <= pend_v_reg;
                    out_num_reg  <= pend_v_reg ? 6'(pend_pat_reg) : 6'd0;
                    out_st_reg   <= ST_OK;
                    out_last_reg <= 1'b1;
                end
                EM_ZERO:
                begin
                    out_mv_reg   <= 1'b0;
                    out_num_reg  <= 6'd0;
                    out_st_reg   <= ST_OK;
                    out_last_reg <= 1'b1;
                end
                default:
                begin
                    out_mv_reg   <= 1'b0;
                    out_num_reg  <= 6'd0;
                    out_st_reg   <= ST_OK;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg        <= NCW'(1);
            pc_reg        <= '0;
            in_pat_reg    <= 1'b0;
            drop_reg      <= ST_OK;
            searched_reg  <= 1'b0;
            cur_reg       <= '0;
            depth_reg     <= '0;
            len_reg       <= '0;
            off_reg       <= '0;
            j_reg         <= '0;
            walk_reg      <= '0;
            found_reg     <= 1'b0;
            new_off_reg   <= '0;
            nres_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Insert path
            if (cmd.ins_begin)
            begin
                if (begin_start)
                begin
                    in_pat_reg <= 1'b1;
                    cur_reg    <= '0;
                    depth_reg  <= '0;
                end
                drop_reg <= drop_next;
            end
            if (cmd.set_long)
                drop_reg <= ST_LONG;
            if (cmd.set_full)
                drop_reg <= ST_FULL;
            if (cmd.ins_descend)
            begin
                cur_reg   <= child_q;
                depth_reg <= depth_reg + DW'(1);
            end
            if (cmd.alloc)
            begin
                cur_reg   <= nc_reg[NW-1:0];
                depth_reg <= depth_reg + DW'(1);
                nc_reg    <= nc_reg + NCW'(1);
            end
            if (cmd.ins_finish && fin_reg)
            begin
                if (drop_reg == ST_OK)
                    pc_reg <= pc_reg + PCW'(1);
                in_pat_reg <= 1'b0;
            end

            // Search path
            if (cmd.sr_begin)
            begin
                searched_reg <= 1'b1;
                len_reg      <= (first_reg ? '0 : len_reg) + BLW'(1);
                off_reg      <= '0;
                found_reg    <= 1'b0;
                nres_reg     <= '0;
                pend_v_reg   <= 1'b0;
            end
            if (cmd.try_init)
            begin
                walk_reg <= '0;
                j_reg    <= off_reg;
            end
            if (cmd.sr_step)
            begin
                walk_reg <= child_q;
                j_reg    <= j_reg + BLW'(1);
            end
            if (cmd.sr_next)
                off_reg <= off_reg + BLW'(1);
            if (cmd.sr_hit)
            begin
                if (!found_reg)
                begin
                    found_reg   <= 1'b1;
                    new_off_reg <= off_reg;
                end
                if (mark_q.term)
                begin
                    pend_v_reg <= 1'b1;
                    nres_reg   <= nres_reg + RW'(1);
                end
                off_reg <= off_reg + BLW'(1);
            end
            if (cmd.sr_shift)
            begin
                if (!found_reg)
                    len_reg <= '0;
                else if (new_off_reg != '0)
                begin
                    len_reg     <= len_reg - BLW'(1);
                    new_off_reg <= new_off_reg - BLW'(1);
                end
            end

            // Clear the whole automaton
            if (do_clear)
            begin
                nc_reg       <= NCW'(1);
                pc_reg       <= '0;
                in_pat_reg   <= 1'b0;
                drop_reg     <= ST_OK;
                searched_reg <= 1'b0;
                cur_reg      <= '0;
                depth_reg    <= '0;
                len_reg      <= '0;
            end

            // Result beat handshake
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_st_reg, out_num_reg};
    assign m_tuser  = out_mv_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: design/multi_pattern_string_matcher_core.sv
// Trie-based multi-pattern matcher over a letter alphabet, one input beat per letter.
// Input beat: tuser selects insert pattern letter, search text letter or
// clear; tdata carries the letter and the start flag; tlast ends a pattern.
// Each input beat gives one or more result beats; the final one has tlast.
// A search letter gives one beat per pattern ending there (longest first,
// at most 16), or one beat with match flag low.
// An insert letter makes at most one child table lookup.
// A search letter walks every suffix of the text cursor string plus the new
// letter through the trie, one child lookup per letter walked, and stops
// early once 16 matches are found; it then realigns the letter buffer.
// One item is in work at a time.
// Reset clears counts and cursors at once; table entries are checked against
// the node count and parent links, so no clearing sweep follows reset.
// A stalled receiver holds the result register and the block waits on it.
module multi_pattern_string_matcher_core #(
    parameter int NODES        = mpsm_pkg::NODES_DEF,
    parameter int ALPHABET     = mpsm_pkg::ALPHABET_DEF,
    parameter int MAX_DEPTH    = mpsm_pkg::MAX_DEPTH_DEF,
    parameter int MAX_PATTERNS = mpsm_pkg::MAX_PATTERNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] letter, [5] first, [7:6] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        s_tlast,   // final_letter
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] pattern_number, [8:6] status, [15:9] zero
    output logic        m_tuser,   // [0] match_valid
    output logic        m_tlast    // last
);
    import mpsm_pkg::*;

    mpsm_cmd_t  cmd;
    mpsm_stat_t stat;

    mpsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpsm_dp #(
        .NODES        (NODES),
        .ALPHABET     (ALPHABET),
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: dv/mpsm_checker.sv
module mpsm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_count
);
    import mpsm_pkg::*;

    localparam int NN    = NODES_DEF;
    localparam int AB    = ALPHABET_DEF;
    localparam int DEPTH = MAX_DEPTH_DEF;
    localparam int PATS  = MAX_PATTERNS_DEF;

    typedef struct packed {
        logic       hit;
        logic [5:0] num;
        logic [2:0] status;
        logic       last;
    } match_beat_t;

    match_beat_t expected_beats[$];
    int          errors = 0;

    // Shadow automaton
    int  kid[NN*AB];
    bit  kid_ok[NN*AB];
    int  hop[NN*AB];
    bit  hop_ok[NN*AB];
    int  sfx[NN];
    bit  sfx_ok[NN];
    int  up_node[NN];
    int  up_ltr[NN];
    int  pat_of[NN];
    bit  is_term[NN];
    int  dep[NN];
    int  used_nodes, pat_total, ins_at, txt_at;
    logic [2:0] drop;
    bit  seen_search, pat_open;

    function automatic void wipe_automaton();
        for (int i = 0; i < NN*AB; i++)
        begin
            kid_ok[i] = 1'b0;
            hop_ok[i] = 1'b0;
            kid[i]    = 0;
            hop[i]    = 0;
        end
        for (int i = 0; i < NN; i++)
        begin
            sfx_ok[i]  = 1'b0;
            is_term[i] = 1'b0;
            dep[i]     = 0;
            up_node[i] = 0;
            up_ltr[i]  = 0;
            pat_of[i]  = 0;
        end
        used_nodes  = 1;
        pat_total   = 0;
        ins_at      = 0;
        txt_at      = 0;
        seen_search = 1'b0;
        pat_open    = 1'b0;
        drop        = ST_OK;
    endfunction

    function automatic int step_to(int v, int c);
        int idx;
        idx = v*AB + c;
        if (!hop_ok[idx])
        begin
            if (kid_ok[idx])
                hop[idx] = kid[idx];
            else if (v == 0)
                hop[idx] = 0;
            else
                hop[idx] = step_to(suffix_of(v), c);
            hop_ok[idx] = 1'b1;
        end
        return hop[idx];
    endfunction

    function automatic int suffix_of(int v);
        if (v == 0)
            return 0;
        if (!sfx_ok[v])
        begin
            if (up_node[v] == 0)
                sfx[v] = 0;
            else
                sfx[v] = step_to(suffix_of(up_node[v]), up_ltr[v]);
            sfx_ok[v] = 1'b1;
        end
        return sfx[v];
    endfunction

    function automatic void queue_beat(bit h, int num, logic [2:0] st, bit lst);
        match_beat_t b;
        b.hit    = h;
        b.num    = num[5:0];
        b.status = st;
        b.last   = lst;
        expected_beats = {expected_beats, b};
    endfunction

    // Work out the result beats of one accepted input beat
    function automatic void predict_letter(logic [1:0] fn, int c, bit first, bit fin);
        int num, idx, t, n;
        int hits[$];
        num = 0;
        if (fn == FUNC_INSERT)
        begin
            if (first || !pat_open)
            begin
                pat_open = 1'b1;
                ins_at   = 0;
                drop     = ST_OK;
                if (pat_total >= PATS)
                    drop = ST_MANY;
            end
            if (drop == ST_OK && seen_search)
                drop = ST_SEARCHED;
            if (drop == ST_OK)
            begin
                idx = ins_at*AB + c;
                if (dep[ins_at] + 1 > DEPTH)
                    drop = ST_LONG;
                else if (!kid_ok[idx])
                begin
                    if (used_nodes >= NN)
                        drop = ST_FULL;
                    else
                    begin
                        n = used_nodes;
                        used_nodes++;
                        kid[idx]    = n;
                        kid_ok[idx] = 1'b1;
                        up_node[n]  = ins_at;
                        up_ltr[n]   = c;
                        dep[n]      = dep[ins_at] + 1;
                        is_term[n]  = 1'b0;
                        ins_at      = n;
                    end
                end
                else
                    ins_at = kid[idx];
            end
            if (fin)
            begin
                if (drop == ST_OK)
                begin
                    is_term[ins_at] = 1'b1;
                    pat_of[ins_at]  = pat_total;
                    num = pat_total;
                    pat_total++;
                end
                pat_open = 1'b0;
            end
            queue_beat(1'b0, num, drop, 1'b1);
        end
        else if (fn == FUNC_SEARCH)
        begin
            if (first)
                txt_at = 0;
            seen_search = 1'b1;
            txt_at = step_to(txt_at, c);
            t = txt_at;
            while (t != 0 && hits.size() < MAX_RESULTS)
            begin
                if (is_term[t])
                    hits = {hits, pat_of[t]};
                t = suffix_of(t);
            end
            if (hits.size() == 0)
                queue_beat(1'b0, 0, ST_OK, 1'b1);
            foreach (hits[i])
                queue_beat(1'b1, hits[i], ST_OK, i == hits.size() - 1);
        end
        else
        begin
            if (fn == FUNC_CLEAR)
                wipe_automaton();
            queue_beat(1'b0, 0, ST_OK, 1'b1);
        end
    endfunction

    assign pending_count = expected_beats.size();
    assign fail_count    = errors;

    initial
    begin
        wipe_automaton();
    end

    // Predict on input beats, compare on output beats
    always @(posedge clk)
    begin
        match_beat_t e;
        if (rst_n && s_tvalid && s_tready)
            predict_letter(s_tuser, int'(s_tdata[4:0]) % AB, s_tdata[5], s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat data=%h user=%b", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                e = expected_beats.pop_front();
                if (m_tuser !== e.hit)
                begin
                    $error("match_valid expected %0d actual %0d", e.hit, m_tuser);
                    errors++;
                end
                if (m_tdata[5:0] !== e.num)
                begin
                    $error("pattern_number expected %0d actual %0d", e.num, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[8:6] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_tdata[8:6]);
                    errors++;
                end
                if (m_tdata[15:9] !== 7'd0)
                begin
                    $error("pad expected 0 actual %0d", m_tdata[15:9]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

endmodule

// File: dv/tb_multi_pattern_string_matcher_core.sv
module tb_multi_pattern_string_matcher_core;
    import mpsm_pkg::*;

    // Func code with no operation behind it
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending_count;
    bit          hold_off = 0;

    always #1 clk = ~clk;

    multi_pattern_string_matcher_core dut (.*);

    mpsm_checker u_checker (.*);

    // Send one letter beat after a random gap
    task automatic send_letter(logic [1:0] fn, logic [4:0] ltr, bit first, bit fin,
                               int gap_max = 12);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, first, ltr};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Insert a word over a small alphabet so text searches hit often
    task automatic insert_word(int len, int span);
        for (int i = 0; i < len; i++)
            send_letter(FUNC_INSERT, 5'($urandom_range(0, span)), i == 0, i == len - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    // Result side: random stalls, with a forced long hold-off
    initial
    begin
        int w;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !held)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                held = 1'b1;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (w != 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("tb_multi_pattern_string_matcher_core failed");
        $finish;
    end

    initial
    begin
        int n, k;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, every func, special cases
        send_letter(FUNC_SEARCH, 5'd0, 1'b1, 1'b0);      // search empty automaton
        send_letter(FUNC_CLEAR, 5'd31, 1'b1, 1'b1);
        send_letter(FUNC_INSERT, 5'd0, 1'b1, 1'b1);      // "a"
        send_letter(FUNC_INSERT, 5'd25, 1'b0, 1'b0);     // no open pattern: starts "z"
        send_letter(FUNC_INSERT, 5'd0, 1'b0, 1'b1);      // "za"
        send_letter(FUNC_INSERT, 5'd0, 1'b1, 1'b1);      // duplicate "a"
        send_letter(FUNC_INSERT, 5'd27, 1'b1, 1'b0);     // wraps to b, abandoned
        for (int i = 0; i < 18; i++)                     // too long
            send_letter(FUNC_INSERT, 5'd0, i == 0, i == 17);
        send_letter(FUNC_INSERT, 5'd3, 1'b1, 1'b1);
        send_letter(FUNC_SPARE, 5'd7, 1'b1, 1'b1);       // unused func
        send_letter(FUNC_SEARCH, 5'd25, 1'b1, 1'b1);
        for (int i = 0; i < 17; i++)                     // long run of a: many matches
            send_letter(FUNC_SEARCH, 5'd0, 1'b0, 1'b0);
        send_letter(FUNC_SEARCH, 5'd31, 1'b0, 1'b1);
        send_letter(FUNC_INSERT, 5'd1, 1'b1, 1'b1);      // insert after search
        drain();

        // Pattern count limit
        send_letter(FUNC_CLEAR, 5'd0, 1'b0, 1'b0, 0);
        for (int p = 0; p < 66; p++)
            send_letter(FUNC_INSERT, 5'(p % 26), 1'b1, 1'b1, 0);
        send_letter(FUNC_SEARCH, 5'd4, 1'b1, 1'b0);
        // Sender pauses until every result is back
        drain();

        // Random phases: clear, then patterns, then text
        for (int ph = 0; ph < 5; ph++)
        begin
            send_letter(FUNC_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                        1'b0);
            n = $urandom_range(2, 4);
            for (int p = 0; p < n; p++)
                insert_word($urandom_range(1, 4), 2);
            if ($urandom_range(0, 1))
                send_letter(FUNC_INSERT, 5'($urandom_range(0, 31)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (ph == 2)
                hold_off = 1;
            k = $urandom_range(12, 16);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_letter(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                ph == 2 ? 0 : 12);
                else
                    send_letter(FUNC_SEARCH,
                                5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                             : $urandom_range(0, 2)),
                                $urandom_range(0, 15) == 0, 1'($urandom_range(0, 1)),
                                ph == 2 ? 0 : 12);
            end
        end
        drain();

        if (fail_count == 0)
            $display("tb_multi_pattern_string_matcher_core passed");
        else
            $display("tb_multi_pattern_string_matcher_core failed");
        $finish;
    end

endmodule
